// ----- design/pptq_pkg.sv -----
package pptq_pkg;

   localparam int QUEUE_DEPTH   = 64;
   localparam int NEST_DEPTH    = 64;
   localparam int PRIORITY_BITS = 8;
   localparam int QIDX_BITS     = $clog2(QUEUE_DEPTH);
   localparam int NIDX_BITS     = $clog2(NEST_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
   localparam int NCNT_BITS     = $clog2(NEST_DEPTH + 1);
   localparam int LEVEL_BITS    = PRIORITY_BITS + 1;

   localparam logic [1:0] REQ_ADD      = 2'd0;
   localparam logic [1:0] REQ_DISPATCH = 2'd1;
   localparam logic [1:0] REQ_FINISH   = 2'd2;
   localparam logic [1:0] REQ_UNUSED   = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NULL      = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_NO_DISP   = 3'd3;
   localparam logic [2:0] ST_NO_RUN    = 3'd4;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] task_handle;
      logic [7:0]  task_priority;
   } req_type_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] dispatched_handle;
      logic [7:0]  dispatched_priority;
      logic [6:0]  queued_count;
      logic [6:0]  nest_depth;
   } rsp_type;

   typedef struct packed {
      logic [15:0]              handle;
      logic [PRIORITY_BITS-1:0] prio;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN_RD, S_SCAN, S_SHIFT_UP, S_SHIFT_DN, S_POP_RD, S_POP, S_RESP
   } state_type;

endpackage

// ----- design/pptq_stack.sv -----
module pptq_stack (
   input  logic                             clock,
   input  logic                             push,
   input  logic [pptq_pkg::NIDX_BITS-1:0]   push_addr,
   input  logic [pptq_pkg::LEVEL_BITS-1:0]  push_data,
   input  logic [pptq_pkg::NIDX_BITS-1:0]   rd_addr,
   output logic [pptq_pkg::LEVEL_BITS-1:0]  rd_data
);
   logic [pptq_pkg::LEVEL_BITS-1:0] mem [pptq_pkg::NEST_DEPTH];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[push_addr] <= push_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- design/pptq_queue_mem.sv -----
module pptq_queue_mem (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [pptq_pkg::QIDX_BITS-1:0]  wr_addr,
   input  pptq_pkg::entry_type             wr_data,
   input  logic [pptq_pkg::QIDX_BITS-1:0]  rd_addr,
   output pptq_pkg::entry_type             rd_data
);
   pptq_pkg::entry_type mem [pptq_pkg::QUEUE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- design/preemptive_priority_task_queue.sv -----
// Priority task queue: up to 64 tasks kept sorted in a single-port-read memory,
// highest priority first, FIFO among equals, plus a 64-deep stack of saved
// running levels. One request at a time: an add scans from the head to find
// its slot (one entry per cycle) and then shifts the tail up one entry per
// cycle; a successful dispatch shifts the queue down one entry per cycle. The
// next request is accepted in the idle state, which is re-entered as the
// response is loaded. The response register lets the next request enter
// while the previous response is still stalled; a new response waits until
// the previous one has been taken.
module preemptive_priority_task_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  pptq_pkg::req_type_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output pptq_pkg::rsp_type             rsp_data
);
   localparam int QB = pptq_pkg::QIDX_BITS;
   localparam int CB = pptq_pkg::QCNT_BITS;
   localparam int NB = pptq_pkg::NCNT_BITS;
   localparam int SB = pptq_pkg::NIDX_BITS;
   localparam int LB = pptq_pkg::LEVEL_BITS;
   localparam int PB = pptq_pkg::PRIORITY_BITS;

   pptq_pkg::state_type     state_ff, state_in;
   pptq_pkg::req_type_type  req_ff;
   logic [CB-1:0] count_ff, count_in;
   logic [NB-1:0] sp_ff, sp_in;
   logic [LB-1:0] level_ff, level_in;
   logic [CB-1:0] idx_ff, idx_in;
   logic [CB-1:0] slot_ff, slot_in;
   logic [2:0]    status_ff, status_in;
   logic [15:0]   dh_ff, dh_in;
   logic [PB-1:0] dp_ff, dp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   pptq_pkg::rsp_type rsp_ff, rsp_in;

   logic                wr_en;
   logic [QB-1:0]       wr_addr, rd_addr;
   pptq_pkg::entry_type wr_data, rd_data, new_entry;
   logic                push;
   logic [LB-1:0]       stk_rd;
   logic                accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != pptq_pkg::S_IDLE);
   assign new_entry = '{handle: req_ff.task_handle, prio: req_ff.task_priority[PB-1:0]};

   pptq_queue_mem u_mem (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   pptq_stack u_stack (
      .clock,
      .push      (push),
      .push_addr (sp_ff[SB-1:0]),
      .push_data (level_ff),
      .rd_addr   (SB'(sp_ff - NB'(1))),
      .rd_data   (stk_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pptq_pkg::S_IDLE;
         count_ff     <= '0;
         sp_ff        <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sp_ff        <= sp_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         req_ff <= req_data;
      end
      idx_ff    <= idx_in;
      slot_ff   <= slot_in;
      status_ff <= status_in;
      dh_ff     <= dh_in;
      dp_ff     <= dp_in;
      rsp_ff    <= rsp_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pptq_pkg::S_IDLE: begin
            if (accept) begin
               state_in = pptq_pkg::S_SCAN_RD;
            end
         end
         pptq_pkg::S_SCAN_RD: begin
            state_in = pptq_pkg::S_RESP;
            case (req_ff.req_type)
               pptq_pkg::REQ_ADD: begin
                  if (req_ff.task_handle != '0 && count_ff < CB'(pptq_pkg::QUEUE_DEPTH)) begin
                     state_in = pptq_pkg::S_SCAN;
                  end
               end
               pptq_pkg::REQ_DISPATCH: begin
                  if (count_ff != '0 && sp_ff < NB'(pptq_pkg::NEST_DEPTH)) begin
                     state_in = pptq_pkg::S_POP_RD;
                  end
               end
               default: ;
            endcase
         end
         pptq_pkg::S_SCAN: begin
            if (idx_ff == count_ff || rd_data.prio < new_entry.prio) begin
               state_in = pptq_pkg::S_SHIFT_UP;
            end
         end
         pptq_pkg::S_SHIFT_UP: begin
            if (idx_ff == slot_ff) state_in = pptq_pkg::S_RESP;
         end
         pptq_pkg::S_POP_RD: state_in = pptq_pkg::S_POP;
         pptq_pkg::S_POP: begin
            if ({1'b0, rd_data.prio} + LB'(1) < level_ff) begin
               state_in = pptq_pkg::S_RESP;
            end else begin
               state_in = pptq_pkg::S_SHIFT_DN;
            end
         end
         pptq_pkg::S_SHIFT_DN: begin
            if (idx_ff >= count_ff) state_in = pptq_pkg::S_RESP;
         end
         pptq_pkg::S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = pptq_pkg::S_IDLE;
         end
         default: state_in = pptq_pkg::S_IDLE;
      endcase
   end

   // Datapath and outputs. In S_SHIFT_UP idx counts down from count to the
   // insertion slot; rd_data holds entry idx-1, read in the previous cycle.
   always_comb begin
      count_in     = count_ff;
      sp_in        = sp_ff;
      level_in     = level_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      status_in    = status_ff;
      dh_in        = dh_ff;
      dp_in        = dp_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = QB'(idx_ff);
      wr_data      = rd_data;
      rd_addr      = QB'(idx_ff);
      push         = 1'b0;
      case (state_ff)
         pptq_pkg::S_IDLE: begin
            idx_in    = '0;
            status_in = pptq_pkg::ST_OK;
            dh_in     = '0;
            dp_in     = '0;
            rd_addr   = '0;
         end
         pptq_pkg::S_SCAN_RD: begin
            idx_in = '0;
            case (req_ff.req_type)
               pptq_pkg::REQ_ADD: begin
                  if (req_ff.task_handle == '0) begin
                     status_in = pptq_pkg::ST_NULL;
                  end else if (count_ff >= CB'(pptq_pkg::QUEUE_DEPTH)) begin
                     status_in = pptq_pkg::ST_FULL;
                  end
               end
               pptq_pkg::REQ_DISPATCH: begin
                  if (count_ff == '0 || sp_ff >= NB'(pptq_pkg::NEST_DEPTH)) begin
                     status_in = pptq_pkg::ST_NO_DISP;
                  end
               end
               pptq_pkg::REQ_FINISH: begin
                  if (sp_ff == '0) begin
                     status_in = pptq_pkg::ST_NO_RUN;
                  end else begin
                     sp_in    = sp_ff - NB'(1);
                     level_in = stk_rd;
                  end
               end
               default: ;
            endcase
            rd_addr = '0;
         end
         pptq_pkg::S_SCAN: begin
            // rd_data holds entry idx (read last cycle).
            if (idx_ff == count_ff || rd_data.prio < new_entry.prio) begin
               // Slot found at idx; the shift begins at the tail.
               slot_in = idx_ff;
               idx_in  = count_ff;
               rd_addr = QB'(count_ff - CB'(1));
            end else begin
               idx_in  = idx_ff + CB'(1);
               rd_addr = QB'(idx_ff + CB'(1));
            end
         end
         pptq_pkg::S_SHIFT_UP: begin
            // Write entry idx: either the shifted entry idx-1 or the new one.
            wr_en = 1'b1;
            if (idx_ff == slot_ff) begin
               wr_data  = new_entry;
               count_in = count_ff + CB'(1);
            end else begin
               wr_data = rd_data;
               idx_in  = idx_ff - CB'(1);
               rd_addr = QB'(idx_ff - CB'(2));
            end
         end
         pptq_pkg::S_POP_RD: begin
            rd_addr = '0;
         end
         pptq_pkg::S_POP: begin
            if ({1'b0, rd_data.prio} + LB'(1) < level_ff) begin
               status_in = pptq_pkg::ST_NO_DISP;
            end else begin
               dh_in    = rd_data.handle;
               dp_in    = rd_data.prio;
               push     = 1'b1;
               sp_in    = sp_ff + NB'(1);
               level_in = {1'b0, rd_data.prio} + LB'(1);
               idx_in   = CB'(1);
               rd_addr  = QB'(1);
            end
         end
         pptq_pkg::S_SHIFT_DN: begin
            // rd_data holds entry idx; write it at idx-1.
            if (idx_ff < count_ff) begin
               wr_en   = 1'b1;
               wr_addr = QB'(idx_ff - CB'(1));
               idx_in  = idx_ff + CB'(1);
               rd_addr = QB'(idx_ff + CB'(1));
            end else begin
               count_in = count_ff - CB'(1);
            end
         end
         pptq_pkg::S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.status              = status_ff;
               rsp_in.dispatched_handle   = dh_ff;
               rsp_in.dispatched_priority = 8'(dp_ff);
               rsp_in.queued_count        = 7'(count_ff);
               rsp_in.nest_depth          = 7'(sp_ff);
            end else begin
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   pptq_pkg::req_type_type req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   pptq_pkg::rsp_type      rsp_data;

   preemptive_priority_task_queue i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Predictor state: the sorted task list, the saved-level stack and the running level.
   logic [15:0]                     task_handles[$];
   logic [7:0]                      task_prios[$];
   logic [pptq_pkg::LEVEL_BITS-1:0] saved_levels[$];
   logic [pptq_pkg::LEVEL_BITS-1:0] run_level;

   pptq_pkg::req_type_type pending_requests[$];
   pptq_pkg::rsp_type      expected_responses[$];
   int                     error_count;
   int                     cycle_count;
   int                     req_wait;
   int                     rsp_wait;
   logic                   req_taken;

   function automatic pptq_pkg::rsp_type predict_response(pptq_pkg::req_type_type r);
      pptq_pkg::rsp_type o;
      int                pos;
      o = '0;
      o.status = pptq_pkg::ST_OK;
      case (r.req_type)
         pptq_pkg::REQ_ADD: begin
            if (r.task_handle == 16'd0) begin
               o.status = pptq_pkg::ST_NULL;
            end else if (task_handles.size() >= pptq_pkg::QUEUE_DEPTH) begin
               o.status = pptq_pkg::ST_FULL;
            end else begin
               pos = 0;
               while (pos < task_prios.size() && task_prios[pos] >= r.task_priority) pos++;
               task_handles.insert(pos, r.task_handle);
               task_prios.insert(pos, r.task_priority);
            end
         end
         pptq_pkg::REQ_DISPATCH: begin
            if (task_handles.size() == 0 || saved_levels.size() >= pptq_pkg::NEST_DEPTH ||
                ({1'b0, task_prios[0]} + 9'd1) < run_level) begin
               o.status = pptq_pkg::ST_NO_DISP;
            end else begin
               o.dispatched_handle   = task_handles.pop_front();
               o.dispatched_priority = task_prios.pop_front();
               saved_levels.push_back(run_level);
               run_level = {1'b0, o.dispatched_priority} + 9'd1;
            end
         end
         pptq_pkg::REQ_FINISH: begin
            if (saved_levels.size() == 0) o.status = pptq_pkg::ST_NO_RUN;
            else run_level = saved_levels.pop_back();
         end
         default: ;
      endcase
      o.queued_count = 7'(task_handles.size());
      o.nest_depth   = 7'(saved_levels.size());
      return o;
   endfunction

   function automatic pptq_pkg::req_type_type make_request(logic [1:0] kind,
                                                           logic [15:0] h,
                                                           logic [7:0] p);
      pptq_pkg::req_type_type r;
      r.req_type      = kind;
      r.task_handle   = h;
      r.task_priority = p;
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A request is taken at the rising edge; the driver acts on it at the next falling edge.
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
   end

   // Request driver.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_wait  <= 0;
      end else if (req_taken) begin
         // Accepted at the last rising edge; predict, then pick the next request.
         expected_responses.push_back(predict_response(req_data));
         void'(pending_requests.pop_front());
         if (pending_requests.size() > 0 && $urandom_range(0, 3) != 0 &&
             $urandom_range(0, 8) == 0) begin
            req_data <= pending_requests[0];
         end else begin
            req_valid <= 1'b0;
            req_wait  <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
         end
      end else if (!req_valid && pending_requests.size() > 0) begin
         if (req_wait > 0) begin
            req_wait <= req_wait - 1;
         end else begin
            req_valid <= 1'b1;
            req_data  <= pending_requests[0];
         end
      end
   end

   // Response stall generator.
   always @(negedge clock) begin
      int w;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait  <= 0;
      end else if (rsp_wait > 0) begin
         rsp_wait  <= rsp_wait - 1;
         rsp_stall <= (rsp_wait > 1);
      end else if (rsp_valid && !rsp_stall) begin
         if ($urandom_range(0, 2) != 0) begin
            w = $urandom_range(0, 8);
            rsp_wait  <= w;
            rsp_stall <= (w != 0);
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      pptq_pkg::rsp_type exp_rsp;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               $display("%0t: response with none expected: %h", $time, rsp_data);
               error_count <= error_count + 1;
            end else begin
               exp_rsp = expected_responses.pop_front();
               if (rsp_data.status !== exp_rsp.status ||
                   rsp_data.dispatched_handle !== exp_rsp.dispatched_handle ||
                   rsp_data.dispatched_priority !== exp_rsp.dispatched_priority ||
                   rsp_data.queued_count !== exp_rsp.queued_count ||
                   rsp_data.nest_depth !== exp_rsp.nest_depth) begin
                  $display("%0t: mismatch: expected %h, actual %h", $time, exp_rsp, rsp_data);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

   initial begin
      int          k;
      int          n;
      int          mode;
      logic [15:0] h;
      logic [7:0]  p;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      req_taken   = 1'b0;
      rsp_stall   = 1'b0;
      run_level   = '0;
      error_count = 0;
      cycle_count = 0;

      // Directed: empty dispatch and finish, null handle, unused type, extremes, FIFO ties,
      // preemption refusal, and nesting.
      pending_requests.push_back(make_request(pptq_pkg::REQ_DISPATCH, 16'h1234, 8'hAB));
      pending_requests.push_back(make_request(pptq_pkg::REQ_FINISH, 16'h0, 8'h0));
      pending_requests.push_back(make_request(pptq_pkg::REQ_ADD, 16'h0, 8'hFF));
      pending_requests.push_back(make_request(pptq_pkg::REQ_UNUSED, 16'hFFFF, 8'hFF));
      pending_requests.push_back(make_request(pptq_pkg::REQ_ADD, 16'hFFFF, 8'h00));
      pending_requests.push_back(make_request(pptq_pkg::REQ_ADD, 16'h0001, 8'hFF));
      pending_requests.push_back(make_request(pptq_pkg::REQ_ADD, 16'h5555, 8'h80));
      pending_requests.push_back(make_request(pptq_pkg::REQ_ADD, 16'hAAAA, 8'h80));
      pending_requests.push_back(make_request(pptq_pkg::REQ_ADD, 16'h00FF, 8'h7F));
      pending_requests.push_back(make_request(pptq_pkg::REQ_DISPATCH, 16'h0, 8'h0));
      pending_requests.push_back(make_request(pptq_pkg::REQ_DISPATCH, 16'h0, 8'h0));
      pending_requests.push_back(make_request(pptq_pkg::REQ_FINISH, 16'h0, 8'h0));
      pending_requests.push_back(make_request(pptq_pkg::REQ_DISPATCH, 16'h0, 8'h0));
      pending_requests.push_back(make_request(pptq_pkg::REQ_DISPATCH, 16'h0, 8'h0));
      pending_requests.push_back(make_request(pptq_pkg::REQ_DISPATCH, 16'h0, 8'h0));
      pending_requests.push_back(make_request(pptq_pkg::REQ_DISPATCH, 16'h0, 8'h0));
      for (k = 0; k < 6; k++)
         pending_requests.push_back(make_request(pptq_pkg::REQ_FINISH, 16'h0, 8'h0));
      pending_requests.push_back(make_request(pptq_pkg::REQ_DISPATCH, 16'h0, 8'h0));

      // Fill the queue past full, then send dispatches and finishes beyond the nest depth.
      for (k = 0; k < pptq_pkg::QUEUE_DEPTH + 2; k++)
         pending_requests.push_back(make_request(pptq_pkg::REQ_ADD,
                                                 16'($urandom_range(1, 65535)), 8'(k)));
      for (k = 0; k < pptq_pkg::NEST_DEPTH + 2; k++)
         pending_requests.push_back(make_request(pptq_pkg::REQ_DISPATCH, 16'($urandom),
                                                 8'($urandom)));
      for (k = 0; k < pptq_pkg::NEST_DEPTH + 2; k++)
         pending_requests.push_back(make_request(pptq_pkg::REQ_FINISH, 16'($urandom),
                                                 8'($urandom)));

      // Random bursts: mostly well-formed adds, dispatches and finishes in
      // phases, with a few nulls and unused types as noise.
      n = 0;
      while (n < 1580) begin
         mode = $urandom_range(0, 2);
         for (k = 0; k < $urandom_range(1, 40); k++) begin
            h = 16'($urandom);
            p = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
            if ($urandom_range(0, 30) == 0) h = 16'h0;
            case ($urandom_range(0, 9) < 6 ? mode : $urandom_range(0, 3))
               0: pending_requests.push_back(make_request(pptq_pkg::REQ_ADD, h, p));
               1: pending_requests.push_back(make_request(pptq_pkg::REQ_DISPATCH, h, p));
               2: pending_requests.push_back(make_request(pptq_pkg::REQ_FINISH, h, p));
               default: pending_requests.push_back(make_request(pptq_pkg::REQ_UNUSED, h, p));
            endcase
            n++;
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while ((pending_requests.size() > 0 || expected_responses.size() > 0) &&
             cycle_count < 2000000)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (cycle_count >= 2000000) begin
         $display("CHECK FAILED");
         $finish;
      end else if (error_count == 0 && expected_responses.size() == 0) begin
         $display("CHECK OK");
         $finish;
      end else begin
         $display("CHECK FAILED");
         $finish;
      end
   end

endmodule

// ----- files.f -----
design/pptq_pkg.sv
design/pptq_stack.sv
design/pptq_queue_mem.sv
design/preemptive_priority_task_queue.sv
verif/tb.sv
